// ===== design/msort_pkg.sv =====
// ----------------------------------------------------------------------------
// msort_pkg: shared constants and types of the merge sorter
// Element width, default buffer depth and the write strobes that the
// sequencer hands to the two buffer memories.
// ----------------------------------------------------------------------------
package msort_pkg;

  // Width of one element
  localparam int unsigned ValueW = 32;

  // Default number of elements a set may hold
  localparam int unsigned DefMaxElements = 64;

  // Write strobes toward the working and the scratch buffer
  typedef struct packed {
    logic work_we;
    logic scr_we;
  } mem_wr_t;

endpackage

// ===== design/msort_ram.sv =====
// ----------------------------------------------------------------------------
// msort_ram: generic buffer memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module msort_ram import msort_pkg::*; #(
  parameter int unsigned WIDTH = ValueW,
  parameter int unsigned DEPTH = DefMaxElements
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register both read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== design/msort_seq.sv =====
// ----------------------------------------------------------------------------
// msort_seq: load, merge and drain sequencer
// Loads elements into the working buffer, runs bottom-up merge passes that
// ping-pong between working and scratch buffer (one element per cycle within a run), then
// streams the sorted set from whichever buffer holds it.
// ----------------------------------------------------------------------------
module msort_seq import msort_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ValueW-1:0]        value_in_i,
  input  logic                            last_in_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ValueW-1:0]        value_out_o,
  output logic                            last_out_o,
  // buffer memories
  output mem_wr_t                         mem_wr_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0] waddr_o,
  output logic [ValueW-1:0]               wdata_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0] raddr_a_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0] raddr_b_o,
  input  logic [ValueW-1:0]               work_rdata_a_i,
  input  logic [ValueW-1:0]               work_rdata_b_i,
  input  logic [ValueW-1:0]               scr_rdata_a_i,
  input  logic [ValueW-1:0]               scr_rdata_b_i
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ELEMENTS);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_RUN   = 4'b0010,
    S_MERGE = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW:0]     width_q, width_d;
  logic [CW-1:0]   lo_q, lo_d;
  logic [CW-1:0]   mid_q, mid_d;
  logic [CW-1:0]   hi_q, hi_d;
  logic [CW-1:0]   a_q, a_d;
  logic [CW-1:0]   b_q, b_d;
  logic [CW-1:0]   k_q, k_d;
  logic [CW-1:0]   out_idx_q, out_idx_d;
  logic            src_sel_q, src_sel_d;

  logic            in_acc;
  logic            out_acc;
  logic            room;
  logic [CW-1:0]   count_inc;
  logic [CW+1:0]   n_ext;
  logic [CW+1:0]   mid_sum;
  logic [CW+1:0]   hi_sum;
  logic [CW-1:0]   k_next;
  logic            take_a;
  logic            merge_we;
  logic signed [ValueW-1:0] src_a;
  logic signed [ValueW-1:0] src_b;
  logic signed [ValueW-1:0] merge_data;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign room    = count_q < MaxCnt;
  assign count_inc = room ? (count_q + 1'b1) : count_q;

  // Run bounds of the next merge, clipped to the set size
  assign n_ext   = {2'b00, n_q};
  assign mid_sum = {2'b00, lo_q} + {1'b0, width_q};
  assign hi_sum  = {2'b00, lo_q} + {width_q, 1'b0};

  // Heads of both runs from the source buffer; ties take the left run
  assign src_a  = $signed(src_sel_q ? scr_rdata_a_i : work_rdata_a_i);
  assign src_b  = $signed(src_sel_q ? scr_rdata_b_i : work_rdata_b_i);
  assign take_a = (a_q < mid_q) && ((b_q >= hi_q) || (src_a <= src_b));
  assign merge_data = take_a ? src_a : src_b;
  assign k_next = k_q + 1'b1;

  // Sequence load, merge passes and drain
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    n_d       = n_q;
    width_d   = width_q;
    lo_d      = lo_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    out_idx_d = out_idx_q;
    src_sel_d = src_sel_q;
    merge_we  = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          count_d = count_inc;
          if (last_in_i) begin
            n_d       = count_inc;
            width_d   = (CW + 1)'(1);
            lo_d      = '0;
            src_sel_d = 1'b0;
            state_d   = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (width_q >= {1'b0, n_q}) begin
          out_idx_d = '0;
          state_d   = S_OUT;
        end else if (lo_q >= n_q) begin
          // end of pass: double the run length, swap buffers
          width_d   = {width_q[CW-1:0], 1'b0};
          lo_d      = '0;
          src_sel_d = !src_sel_q;
        end else begin
          mid_d   = (mid_sum > n_ext) ? n_q : mid_sum[CW-1:0];
          hi_d    = (hi_sum > n_ext) ? n_q : hi_sum[CW-1:0];
          a_d     = lo_q;
          b_d     = (mid_sum > n_ext) ? n_q : mid_sum[CW-1:0];
          k_d     = lo_q;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        merge_we = 1'b1;
        if (take_a) begin
          a_d = a_q + 1'b1;
        end else begin
          b_d = b_q + 1'b1;
        end
        k_d = k_next;
        if (k_next == hi_q) begin
          lo_d    = hi_q;
          state_d = S_RUN;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_out_o) begin
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            out_idx_d = out_idx_q + 1'b1;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Hold or advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      n_q       <= '0;
      width_q   <= '0;
      lo_q      <= '0;
      mid_q     <= '0;
      hi_q      <= '0;
      a_q       <= '0;
      b_q       <= '0;
      k_q       <= '0;
      out_idx_q <= '0;
      src_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      n_q       <= n_d;
      width_q   <= width_d;
      lo_q      <= lo_d;
      mid_q     <= mid_d;
      hi_q      <= hi_d;
      a_q       <= a_d;
      b_q       <= b_d;
      k_q       <= k_d;
      out_idx_q <= out_idx_d;
      src_sel_q <= src_sel_d;
    end
  end

  // Memory ports: loading writes the working buffer, merging the one it does not read
  assign mem_wr_o.work_we = (in_acc && room) || (merge_we && src_sel_q);
  assign mem_wr_o.scr_we  = merge_we && !src_sel_q;
  assign waddr_o = (state_q == S_LOAD) ? count_q[AW-1:0] : k_q[AW-1:0];
  assign wdata_o = (state_q == S_LOAD) ? value_in_i : merge_data;

  // Fetch the next run heads, or the next element to drain
  assign raddr_a_o = (state_d == S_OUT) ? out_idx_d[AW-1:0] : a_d[AW-1:0];
  assign raddr_b_o = b_d[AW-1:0];

  // Channels
  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_OUT);
  assign value_out_o = src_a;
  assign last_out_o  = (out_idx_q == (n_q - 1'b1));

  // Run pointers stay inside their runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MERGE |-> (a_q <= mid_q && b_q <= hi_q))
    else $error("merge pointer left its run");

  // Output position equals elements taken from both runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MERGE |-> ({1'b0, k_q} + {1'b0, mid_q} == {1'b0, a_q} + {1'b0, b_q}))
    else $error("merge output position out of step");

  // Fill count never exceeds the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("fill count beyond depth");

  // Drain index stays inside the set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> out_idx_q < n_q)
    else $error("drain index beyond set");

  // A final element ends loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && in_valid_i && last_in_i) |=> state_q == S_RUN)
    else $error("final element did not start the sort");

endmodule

// ===== design/merge_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// merge_sorter_unit: stable ascending merge sort of signed 32-bit elements
// Collects a set, sorts it in two buffer memories, streams it back sorted.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one element per item, last_in_i
//   marks the final element of a set. Loading takes one cycle per item.
//   Elements beyond MAX_ELEMENTS are dropped; a dropped final element still
//   starts the sort. in_stall_o is high from the final element until the
//   sorted set has been fully taken.
//   Sort: bottom-up passes, ceil(log2 n) of them for n elements. A pass
//   merges one element per cycle within a run, bounded by the single
//   write port of the destination buffer.
//   Output channel (out_valid_o / out_stall_i): one sorted element per
//   cycle, last_out_o on the greatest. The first element is shown when
//   the drain state is entered. While out_stall_i is high the element holds.
//   Reset clears the fill count; the buffers need no clearing, since only
//   loaded entries are ever used.
// ----------------------------------------------------------------------------
module merge_sorter_unit import msort_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ValueW-1:0] value_in_i,
  input  logic                     last_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ValueW-1:0] value_out_o,
  output logic                     last_out_o
);

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  mem_wr_t           mem_wr;
  logic [AW-1:0]     waddr;
  logic [ValueW-1:0] wdata;
  logic [AW-1:0]     raddr_a;
  logic [AW-1:0]     raddr_b;
  logic [ValueW-1:0] work_rdata_a;
  logic [ValueW-1:0] work_rdata_b;
  logic [ValueW-1:0] scr_rdata_a;
  logic [ValueW-1:0] scr_rdata_b;

  // Working buffer
  msort_ram #(
    .WIDTH (ValueW),
    .DEPTH (MAX_ELEMENTS)
  ) u_work_ram (
    .clk_i     (clk_i),
    .we_i      (mem_wr.work_we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (work_rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (work_rdata_b)
  );

  // Scratch buffer
  msort_ram #(
    .WIDTH (ValueW),
    .DEPTH (MAX_ELEMENTS)
  ) u_scr_ram (
    .clk_i     (clk_i),
    .we_i      (mem_wr.scr_we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (scr_rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (scr_rdata_b)
  );

  // Load, merge and drain sequencer
  msort_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_in_i     (value_in_i),
    .last_in_i      (last_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_out_o    (value_out_o),
    .last_out_o     (last_out_o),
    .mem_wr_o       (mem_wr),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_a_o      (raddr_a),
    .raddr_b_o      (raddr_b),
    .work_rdata_a_i (work_rdata_a),
    .work_rdata_b_i (work_rdata_b),
    .scr_rdata_a_i  (scr_rdata_a),
    .scr_rdata_b_i  (scr_rdata_b)
  );

endmodule
